// File: rtl/amc_pkg.sv
// amc_pkg: types, constants and codes shared by the ARP/MAC cache modules.
// No dependencies.
package amc_pkg;

  // table geometry
  localparam int unsigned ENTRIES = 4;
  localparam int unsigned IDX_W   = (ENTRIES > 2) ? $clog2(ENTRIES) : 1;
  localparam int unsigned IP_W    = 32;
  localparam int unsigned MAC_W   = 48;
  localparam int unsigned ETYPE_W = 16;
  localparam int unsigned SLOT_W  = 2;
  localparam int unsigned STAT_W  = 3;

  localparam logic [ETYPE_W-1:0] IPV4_TYPE = 16'h0800;

  // operation codes
  typedef enum logic {
    OP_LEARN  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_HIT     = 3'd0,
    ST_LEARNED = 3'd1,
    ST_MISS    = 3'd2,
    ST_FULL    = 3'd3,
    ST_NOT_IP  = 3'd4
  } status_e;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_e;

  // search token handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic [IP_W-1:0]  ip;
    logic             found;
    logic [IDX_W-1:0] hit_idx;
    logic [MAC_W-1:0] mac;
    logic             have_free;
    logic [IDX_W-1:0] free_idx;
  } amc_tok_t;

  // write-back broadcast to all cells
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } amc_wr_t;

endpackage

// File: rtl/amc_cell.sv
// amc_cell: one cache entry plus one stage of the search chain.
// Depends on amc_pkg.
module amc_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [amc_pkg::IDX_W-1:0] idx_i,
  input  amc_pkg::amc_tok_t  tok_i,
  output amc_pkg::amc_tok_t  tok_o,
  input  amc_pkg::amc_wr_t   wr_i
);

  logic                      init_q;
  logic [amc_pkg::IP_W-1:0]  ip_q;
  logic [amc_pkg::MAC_W-1:0] mac_q;
  logic [amc_pkg::IP_W-1:0]  entry_ip;
  logic [amc_pkg::MAC_W-1:0] entry_mac;
  logic                      wr_hit;
  amc_pkg::amc_tok_t         tok_d, tok_q;

  assign wr_hit = wr_i.en && (wr_i.idx == idx_i);

  // until first written, entry 0 is broadcast and the rest are free
  always_comb begin
    if (init_q) begin
      entry_ip  = (idx_i == '0) ? '1 : '0;
      entry_mac = (idx_i == '0) ? '1 : '0;
    end else begin
      entry_ip  = ip_q;
      entry_mac = mac_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= 1'b1;
    end else if (wr_hit) begin
      init_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      ip_q  <= wr_i.ip;
      mac_q <= wr_i.mac;
    end
  end

  // compare this entry; a token that already hit passes unchanged
  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && !tok_i.found) begin
      if (!tok_i.have_free && (entry_ip == '0)) begin
        tok_d.have_free = 1'b1;
        tok_d.free_idx  = idx_i;
      end
      if (entry_ip == tok_i.ip) begin
        tok_d.found   = 1'b1;
        tok_d.hit_idx = idx_i;
        tok_d.mac     = entry_mac;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// File: rtl/arp_mac_cache_unit.sv
// arp_mac_cache_unit: IPv4-to-MAC cache built as a chain of entry cells.
// Depends on amc_pkg and amc_cell.
//
//   channel | signals                                          | direction
//   --------+--------------------------------------------------+----------
//   in      | in_valid_i/in_ready_o, op, ether_type, ip, mac   | to block
//   out     | out_valid_o/out_ready_i, status, mac_out, slot   | from block
//
// An IPv4 item walks the cell chain one entry per cycle, through each cell's
// register; the controller then stores the result and loads it into the
// output register. A non-IPv4 item skips the chain. One item is in the chain
// at a time; a new one is taken only in idle. A finished result waits in the
// output register while the next item is taken; a second result waits in the
// done state until the output register frees. Reset puts broadcast in entry 0.
module arp_mac_cache_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [15:0] ether_type_i,
  input  logic [31:0] ip_address_i,
  input  logic [47:0] mac_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [47:0] mac_out_o,
  output logic [1:0]  slot_o
);

  amc_pkg::state_e           state_q, state_d;
  amc_pkg::amc_tok_t         tok [amc_pkg::ENTRIES+1];
  amc_pkg::amc_wr_t          wr;
  logic                      in_fire;
  logic                      is_ipv4;
  logic                      chain_done;
  logic                      out_free;
  logic                      op_q;
  logic [amc_pkg::MAC_W-1:0] mac_in_q;

  // pending result and output register
  amc_pkg::status_e                res_status_q, res_status_d;
  logic [amc_pkg::MAC_W-1:0]       res_mac_q, res_mac_d;
  logic [amc_pkg::SLOT_W-1:0]      res_slot_q, res_slot_d;
  logic                            out_valid_q;
  amc_pkg::status_e                out_status_q;
  logic [amc_pkg::MAC_W-1:0]       out_mac_q;
  logic [amc_pkg::SLOT_W-1:0]      out_slot_q;
  logic                            out_load;

  assign in_ready_o = (state_q == amc_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_ipv4    = (ether_type_i == amc_pkg::IPV4_TYPE);
  assign chain_done = tok[amc_pkg::ENTRIES].valid;
  assign out_free   = !out_valid_q || out_ready_i;

  // token entering the first cell
  always_comb begin
    tok[0]       = '0;
    tok[0].valid = in_fire && is_ipv4;
    tok[0].ip    = ip_address_i;
  end

  // cell chain
  for (genvar k = 0; k < amc_pkg::ENTRIES; k++) begin : g_cell
    amc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (amc_pkg::IDX_W'(k)),
      .tok_i  (tok[k]),
      .tok_o  (tok[k+1]),
      .wr_i   (wr)
    );
  end

  // item fields kept for the end of the walk
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q     <= op_i;
      mac_in_q <= mac_address_i;
    end
  end

  // controller: next state, result and write-back
  always_comb begin
    state_d      = state_q;
    res_status_d = res_status_q;
    res_mac_d    = res_mac_q;
    res_slot_d   = res_slot_q;
    out_load     = 1'b0;
    wr           = '0;
    wr.idx       = tok[amc_pkg::ENTRIES].free_idx;
    wr.ip        = tok[amc_pkg::ENTRIES].ip;
    wr.mac       = mac_in_q;
    unique case (state_q)
      amc_pkg::S_IDLE: begin
        if (in_fire) begin
          if (is_ipv4) begin
            state_d = amc_pkg::S_WALK;
          end else begin
            res_status_d = amc_pkg::ST_NOT_IP;
            res_mac_d    = '0;
            res_slot_d   = '0;
            state_d      = amc_pkg::S_DONE;
          end
        end
      end
      amc_pkg::S_WALK: begin
        if (chain_done) begin
          state_d    = amc_pkg::S_DONE;
          res_mac_d  = '0;
          res_slot_d = '0;
          if (tok[amc_pkg::ENTRIES].found) begin
            res_status_d = amc_pkg::ST_HIT;
            res_slot_d   = amc_pkg::SLOT_W'(tok[amc_pkg::ENTRIES].hit_idx);
            if (op_q == amc_pkg::OP_LOOKUP) begin
              res_mac_d = tok[amc_pkg::ENTRIES].mac;
            end
          end else if (op_q == amc_pkg::OP_LOOKUP) begin
            res_status_d = amc_pkg::ST_MISS;
          end else if (!tok[amc_pkg::ENTRIES].have_free) begin
            res_status_d = amc_pkg::ST_FULL;
          end else begin
            res_status_d = amc_pkg::ST_LEARNED;
            res_slot_d   = amc_pkg::SLOT_W'(tok[amc_pkg::ENTRIES].free_idx);
            wr.en        = 1'b1;
          end
        end
      end
      amc_pkg::S_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = amc_pkg::S_IDLE;
        end
      end
      default: state_d = amc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= amc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_mac_q    <= res_mac_d;
    res_slot_q   <= res_slot_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status_q;
      out_mac_q    <= res_mac_q;
      out_slot_q   <= res_slot_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign mac_out_o   = out_mac_q;
  assign slot_o      = out_slot_q;

endmodule
